### src/two_joint_pid_with_deadband_top_assert.svh
// Assertion macros used by the two-joint PID controller top level.
`ifndef TWO_JOINT_PID_WITH_DEADBAND_TOP_ASSERT_SVH
`define TWO_JOINT_PID_WITH_DEADBAND_TOP_ASSERT_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define TJPID_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define TJPID_ASSERT(label, prop, msg) \
  `TJPID_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### src/tjpid_pkg.sv
// Shared constants, types and register codes of the two-joint PID controller.
`timescale 1ns / 1ps

package tjpid_pkg;

  // Angle and error widths.
  localparam int ANGLE_BITS = 10;
  localparam int ERR_BITS   = ANGLE_BITS + 1;
  localparam int Q_BITS     = ANGLE_BITS - 3;

  // Gain, deadband and drive widths.
  localparam int KP_BITS    = 16;
  localparam int KG_BITS    = 24;
  localparam int DB_BITS    = 8;
  localparam int DRIVE_BITS = 32;
  localparam int FRAC_BITS  = 16;

  // Configuration port widths.
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;

  // Division by ten as a reciprocal multiply, exact for magnitudes below 2^18.
  localparam int DIV10_MULT      = 52429;
  localparam int DIV10_SHIFT     = 19;
  localparam int DIV10_PROD_BITS = DIV10_SHIFT + Q_BITS;

  // Product and accumulator widths.
  localparam int KP_PROD_BITS = KP_BITS + 1 + ERR_BITS;
  localparam int KI_PROD_BITS = KG_BITS + 1 + DRIVE_BITS;
  localparam int KD_PROD_BITS = KG_BITS + 1 + ERR_BITS;
  localparam int ACC_BITS     = KI_PROD_BITS + 1;
  localparam int QT_BITS      = ACC_BITS - FRAC_BITS;

  // Stream data widths, padded to whole bytes.
  localparam int S_TDATA_BITS = ((2 * ANGLE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS = ((DRIVE_BITS + 1 + 7) / 8) * 8;

  // Settle window, exclusive on both ends.
  localparam int SETTLE_LIMIT = 100;
  localparam logic signed [QT_BITS-1:0] SETTLE_HI = QT_BITS'(SETTLE_LIMIT);
  localparam logic signed [QT_BITS-1:0] SETTLE_LO = -QT_BITS'(SETTLE_LIMIT);
  localparam logic signed [DRIVE_BITS-1:0] DRIVE_SETTLE_HI = DRIVE_BITS'(SETTLE_LIMIT);
  localparam logic signed [DRIVE_BITS-1:0] DRIVE_SETTLE_LO = -DRIVE_BITS'(SETTLE_LIMIT);

  // Signed 32-bit limits.
  localparam logic signed [DRIVE_BITS-1:0] DRIVE_MAX = {1'b0, {(DRIVE_BITS-1){1'b1}}};
  localparam logic signed [DRIVE_BITS-1:0] DRIVE_MIN = {1'b1, {(DRIVE_BITS-1){1'b0}}};

  // Register reset values.
  localparam logic [KP_BITS-1:0] KP_SHOULDER_RST = KP_BITS'(45);
  localparam logic [KG_BITS-1:0] KI_SHOULDER_RST = KG_BITS'(1966);
  localparam logic [KG_BITS-1:0] KD_SHOULDER_RST = KG_BITS'(0);
  localparam logic [KP_BITS-1:0] KP_ELBOW_RST    = KP_BITS'(20);
  localparam logic [KG_BITS-1:0] KI_ELBOW_RST    = KG_BITS'(655);
  localparam logic [KG_BITS-1:0] KD_ELBOW_RST    = KG_BITS'(0);
  localparam logic [DB_BITS-1:0] DB_SHOULDER_RST = DB_BITS'(10);
  localparam logic [DB_BITS-1:0] DB_ELBOW_RST    = DB_BITS'(5);

  // Register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_KP_SHOULDER = 3'd0,
    CFG_KI_SHOULDER = 3'd1,
    CFG_KD_SHOULDER = 3'd2,
    CFG_KP_ELBOW    = 3'd3,
    CFG_KI_ELBOW    = 3'd4,
    CFG_KD_ELBOW    = 3'd5,
    CFG_DB_SHOULDER = 3'd6,
    CFG_DB_ELBOW    = 3'd7
  } cfg_reg_e;

  // Gains and deadbands, indexed by joint (0 shoulder, 1 elbow).
  typedef struct packed {
    logic [1:0][KP_BITS-1:0] kp;
    logic [1:0][KG_BITS-1:0] ki;
    logic [1:0][KG_BITS-1:0] kd;
    logic [1:0][DB_BITS-1:0] db;
  } gains_t;

  // Error stage payload.
  typedef struct packed {
    logic                       joint;
    logic signed [ANGLE_BITS-1:0] sp;
    logic signed [ANGLE_BITS-1:0] meas;
    logic signed [ERR_BITS-1:0] err;
    logic [ANGLE_BITS-1:0]      mag;
    logic signed [Q_BITS:0]     quot;
  } err_stage_t;

  // Joint state stage payload.
  typedef struct packed {
    logic                         joint;
    logic signed [ERR_BITS-1:0]   err_db;
    logic signed [DRIVE_BITS-1:0] isum;
    logic signed [ERR_BITS-1:0]   diff;
  } pid_stage_t;

  // Load enables of the multiply and accumulate stages.
  typedef struct packed {
    logic ld_prod;
    logic ld_acc;
  } mac_ctl_t;

endpackage

### src/two_joint_pid_with_deadband_top.sv
// Top level of the two-joint PID position controller with deadband.
`timescale 1ns / 1ps
`include "two_joint_pid_with_deadband_top_assert.svh"

// Two-joint PID controller. Each input transfer carries a joint select in
// tuser and a setpoint and measured angle in tdata; each one yields exactly
// one result transfer with the saturated drive and a settled flag. The block
// is a six-register pipeline (input, error and divide-by-ten, joint state,
// products, accumulate, result) and takes one item per cycle while the
// result side does not stall it. The joint state register is updated once
// per item, which lets items for the same joint follow each other back to
// back. Gains and deadbands are written through the cfg port; the user must
// write them only while no item is in flight, as the block itself does not
// enforce it.
module two_joint_pid_with_deadband_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: setpoint [9:0], measured_angle [19:10], zero padding above.
  input  logic [tjpid_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
  // tuser: joint [0].
  input  logic [0:0]                          s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: drive [31:0], settled [32], zero padding above.
  output logic [tjpid_pkg::M_TDATA_BITS-1:0]  m_axis_tdata,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tjpid_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [tjpid_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  tjpid_pkg::gains_t                         gains;

  // Stage valids and ready chain.
  logic in_v_q, err_v_q, pid_v_q, prod_v_q, acc_v_q, out_v_q;
  logic in_rdy, err_rdy, pid_rdy, prod_rdy, acc_rdy, out_rdy;

  // Input stage.
  logic                                      in_joint_q;
  logic signed [tjpid_pkg::ANGLE_BITS-1:0]   in_sp_q;
  logic signed [tjpid_pkg::ANGLE_BITS-1:0]   in_meas_q;

  // Error stage.
  logic signed [tjpid_pkg::ERR_BITS-1:0]     err_d;
  logic signed [tjpid_pkg::ERR_BITS-1:0]     err_abs;
  logic [tjpid_pkg::ANGLE_BITS-1:0]          mag_d;
  logic [tjpid_pkg::DIV10_PROD_BITS-1:0]     div_prod;
  logic [tjpid_pkg::Q_BITS-1:0]              quot_mag;
  logic signed [tjpid_pkg::Q_BITS:0]         quot_d;
  tjpid_pkg::err_stage_t                     err_stg_q;

  // Joint state and multiply stages.
  tjpid_pkg::pid_stage_t                     pid_stg;
  tjpid_pkg::mac_ctl_t                       mac_ctl;
  logic                                      acc_joint;
  logic signed [tjpid_pkg::ACC_BITS-1:0]     acc;

  // Result stage.
  logic                                      round_up;
  logic signed [tjpid_pkg::QT_BITS-1:0]      qt;
  logic signed [tjpid_pkg::QT_BITS-1:0]      qt_tz;
  logic [tjpid_pkg::QT_BITS-tjpid_pkg::DRIVE_BITS:0] qt_hi;
  logic signed [tjpid_pkg::DRIVE_BITS-1:0]   drive_d;
  logic                                      in_band;
  logic [1:0]                                inband_q;
  logic signed [tjpid_pkg::DRIVE_BITS-1:0]   out_drive_q;
  logic                                      out_settled_q;
  logic                                      out_joint_q;
  logic                                      out_in_window;

  // Configuration registers.
  tjpid_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .gains_o     (gains)
  );

  // A stage takes new data when it is empty or its content moves on.
  assign out_rdy  = !out_v_q  || m_axis_tready;
  assign acc_rdy  = !acc_v_q  || out_rdy;
  assign prod_rdy = !prod_v_q || acc_rdy;
  assign pid_rdy  = !pid_v_q  || prod_rdy;
  assign err_rdy  = !err_v_q  || pid_rdy;
  assign in_rdy   = !in_v_q   || err_rdy;
  assign s_axis_tready = in_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      err_v_q  <= 1'b0;
      pid_v_q  <= 1'b0;
      prod_v_q <= 1'b0;
      acc_v_q  <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      if (in_rdy)   in_v_q   <= s_axis_tvalid;
      if (err_rdy)  err_v_q  <= in_v_q;
      if (pid_rdy)  pid_v_q  <= err_v_q;
      if (prod_rdy) prod_v_q <= pid_v_q;
      if (acc_rdy)  acc_v_q  <= prod_v_q;
      if (out_rdy)  out_v_q  <= acc_v_q;
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (in_rdy && s_axis_tvalid) begin
      in_joint_q <= s_axis_tuser[0];
      in_sp_q    <= s_axis_tdata[tjpid_pkg::ANGLE_BITS-1:0];
      in_meas_q  <= s_axis_tdata[2*tjpid_pkg::ANGLE_BITS-1:tjpid_pkg::ANGLE_BITS];
    end
  end

  // Error and error/10 truncated toward zero, through a reciprocal multiply.
  always_comb begin
    err_d    = tjpid_pkg::ERR_BITS'(in_sp_q) - tjpid_pkg::ERR_BITS'(in_meas_q);
    err_abs  = err_d[tjpid_pkg::ERR_BITS-1] ? -err_d : err_d;
    mag_d    = err_abs[tjpid_pkg::ANGLE_BITS-1:0];
    div_prod = tjpid_pkg::DIV10_PROD_BITS'(mag_d)
             * tjpid_pkg::DIV10_PROD_BITS'(tjpid_pkg::DIV10_MULT);
    quot_mag = div_prod[tjpid_pkg::DIV10_SHIFT +: tjpid_pkg::Q_BITS];
    quot_d   = err_d[tjpid_pkg::ERR_BITS-1] ? -$signed({1'b0, quot_mag})
                                            : $signed({1'b0, quot_mag});
  end

  always_ff @(posedge clk_i) begin
    if (err_rdy && in_v_q) begin
      err_stg_q.joint <= in_joint_q;
      err_stg_q.sp    <= in_sp_q;
      err_stg_q.meas  <= in_meas_q;
      err_stg_q.err   <= err_d;
      err_stg_q.mag   <= mag_d;
      err_stg_q.quot  <= quot_d;
    end
  end

  // Per-joint state update.
  tjpid_joint u_joint (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (pid_rdy && err_v_q),
    .stg_i  (err_stg_q),
    .db_i   (gains.db),
    .stg_o  (pid_stg)
  );

  // Products and accumulation.
  assign mac_ctl.ld_prod = prod_rdy && pid_v_q;
  assign mac_ctl.ld_acc  = acc_rdy && prod_v_q;

  tjpid_mac u_mac (
    .clk_i   (clk_i),
    .ctl_i   (mac_ctl),
    .stg_i   (pid_stg),
    .gains_i (gains),
    .joint_o (acc_joint),
    .acc_o   (acc)
  );

  // Divide by 2^16 toward zero, then saturate to 32 bits.
  always_comb begin
    round_up = acc[tjpid_pkg::ACC_BITS-1] && (acc[tjpid_pkg::FRAC_BITS-1:0] != '0);
    qt       = acc[tjpid_pkg::ACC_BITS-1:tjpid_pkg::FRAC_BITS];
    qt_tz    = qt + $signed({{(tjpid_pkg::QT_BITS-1){1'b0}}, round_up});
    qt_hi    = qt_tz[tjpid_pkg::QT_BITS-1:tjpid_pkg::DRIVE_BITS-1];
    if (!((&qt_hi) || !(|qt_hi))) begin
      drive_d = qt_tz[tjpid_pkg::QT_BITS-1] ? tjpid_pkg::DRIVE_MIN : tjpid_pkg::DRIVE_MAX;
    end else begin
      drive_d = qt_tz[tjpid_pkg::DRIVE_BITS-1:0];
    end
    in_band = (qt_tz < tjpid_pkg::SETTLE_HI) && (qt_tz > tjpid_pkg::SETTLE_LO);
  end

  // Per-joint settle flags stand in for the last drive values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inband_q <= 2'b11;
    end else if (out_rdy && acc_v_q) begin
      inband_q[acc_joint] <= in_band;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_rdy && acc_v_q) begin
      out_drive_q   <= drive_d;
      out_settled_q <= in_band && inband_q[~acc_joint];
      out_joint_q   <= acc_joint;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = tjpid_pkg::M_TDATA_BITS'({out_settled_q, out_drive_q});

  // The waiting drive lies inside the settle window.
  assign out_in_window = (out_drive_q < tjpid_pkg::DRIVE_SETTLE_HI)
                      && (out_drive_q > tjpid_pkg::DRIVE_SETTLE_LO);

  // The settled flag of a waiting result matches both joints' settle flags.
  `TJPID_ASSERT(a_settled_flags, out_v_q |-> (out_settled_q == (&inband_q)), "settled flag")

  // A drive of a settled joint lies inside the settle window.
  `TJPID_ASSERT(a_drive_window, (out_v_q && inband_q[out_joint_q]) |-> out_in_window, "window")

  // The input side only stalls behind a result that is not taken.
  `TJPID_ASSERT(a_stall_cause, !s_axis_tready |-> (out_v_q && !m_axis_tready), "input stall")

endmodule

### src/tjpid_cfg.sv
// Configuration register file holding the gains and deadbands of both joints.
`timescale 1ns / 1ps

module tjpid_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tjpid_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [tjpid_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output tjpid_pkg::gains_t                   gains_o
);

  tjpid_pkg::gains_t gains_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register writes, truncated to each register's width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.kp[0] <= tjpid_pkg::KP_SHOULDER_RST;
      gains_q.ki[0] <= tjpid_pkg::KI_SHOULDER_RST;
      gains_q.kd[0] <= tjpid_pkg::KD_SHOULDER_RST;
      gains_q.kp[1] <= tjpid_pkg::KP_ELBOW_RST;
      gains_q.ki[1] <= tjpid_pkg::KI_ELBOW_RST;
      gains_q.kd[1] <= tjpid_pkg::KD_ELBOW_RST;
      gains_q.db[0] <= tjpid_pkg::DB_SHOULDER_RST;
      gains_q.db[1] <= tjpid_pkg::DB_ELBOW_RST;
    end else if (cfg_valid_i) begin
      unique case (tjpid_pkg::cfg_reg_e'(cfg_index_i))
        tjpid_pkg::CFG_KP_SHOULDER: gains_q.kp[0] <= cfg_data_i[tjpid_pkg::KP_BITS-1:0];
        tjpid_pkg::CFG_KI_SHOULDER: gains_q.ki[0] <= cfg_data_i[tjpid_pkg::KG_BITS-1:0];
        tjpid_pkg::CFG_KD_SHOULDER: gains_q.kd[0] <= cfg_data_i[tjpid_pkg::KG_BITS-1:0];
        tjpid_pkg::CFG_KP_ELBOW:    gains_q.kp[1] <= cfg_data_i[tjpid_pkg::KP_BITS-1:0];
        tjpid_pkg::CFG_KI_ELBOW:    gains_q.ki[1] <= cfg_data_i[tjpid_pkg::KG_BITS-1:0];
        tjpid_pkg::CFG_KD_ELBOW:    gains_q.kd[1] <= cfg_data_i[tjpid_pkg::KG_BITS-1:0];
        tjpid_pkg::CFG_DB_SHOULDER: gains_q.db[0] <= cfg_data_i[tjpid_pkg::DB_BITS-1:0];
        tjpid_pkg::CFG_DB_ELBOW:    gains_q.db[1] <= cfg_data_i[tjpid_pkg::DB_BITS-1:0];
      endcase
    end
  end

  assign gains_o = gains_q;

endmodule

### src/tjpid_joint.sv
// Per-joint state: setpoint tracking, saturating integral, derivative and deadband.
`timescale 1ns / 1ps

module tjpid_joint (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  tjpid_pkg::err_stage_t               stg_i,
  input  logic [1:0][tjpid_pkg::DB_BITS-1:0]  db_i,
  output tjpid_pkg::pid_stage_t               stg_o
);

  logic                                      seen_q    [2];
  logic signed [tjpid_pkg::ANGLE_BITS-1:0]   prev_sp_q [2];
  logic signed [tjpid_pkg::DRIVE_BITS-1:0]   isum_q    [2];
  logic signed [tjpid_pkg::ANGLE_BITS-1:0]   last_pos_q[2];

  logic                                      sp_change;
  logic signed [tjpid_pkg::DRIVE_BITS-1:0]   isum_base;
  logic signed [tjpid_pkg::DRIVE_BITS:0]     isum_sum;
  logic signed [tjpid_pkg::DRIVE_BITS-1:0]   isum_d;
  logic signed [tjpid_pkg::ERR_BITS-1:0]     diff_d;
  logic                                      in_deadband;
  tjpid_pkg::pid_stage_t                     stg_d;
  tjpid_pkg::pid_stage_t                     stg_q;

  // A setpoint change clears the integral; the first setpoint only loads the store.
  always_comb begin
    sp_change = seen_q[stg_i.joint] && (prev_sp_q[stg_i.joint] != stg_i.sp);
    isum_base = sp_change ? '0 : isum_q[stg_i.joint];
    isum_sum  = (tjpid_pkg::DRIVE_BITS+1)'(isum_base)
              + (tjpid_pkg::DRIVE_BITS+1)'(stg_i.quot);
    if (isum_sum[tjpid_pkg::DRIVE_BITS] != isum_sum[tjpid_pkg::DRIVE_BITS-1]) begin
      isum_d = isum_sum[tjpid_pkg::DRIVE_BITS] ? tjpid_pkg::DRIVE_MIN : tjpid_pkg::DRIVE_MAX;
    end else begin
      isum_d = isum_sum[tjpid_pkg::DRIVE_BITS-1:0];
    end
  end

  // Derivative operand and deadbanded proportional error.
  always_comb begin
    diff_d = tjpid_pkg::ERR_BITS'(last_pos_q[stg_i.joint])
           - tjpid_pkg::ERR_BITS'(stg_i.meas);
    in_deadband  = stg_i.mag < tjpid_pkg::ANGLE_BITS'(db_i[stg_i.joint]);
    stg_d.joint  = stg_i.joint;
    stg_d.err_db = in_deadband ? '0 : stg_i.err;
    stg_d.isum   = isum_d;
    stg_d.diff   = diff_d;
  end

  // Joint state update, one item per transfer into the next stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 2; k++) begin
        seen_q[k]     <= 1'b0;
        prev_sp_q[k]  <= '0;
        isum_q[k]     <= '0;
        last_pos_q[k] <= '0;
      end
    end else if (load_i) begin
      seen_q[stg_i.joint]     <= 1'b1;
      prev_sp_q[stg_i.joint]  <= stg_i.sp;
      isum_q[stg_i.joint]     <= isum_d;
      last_pos_q[stg_i.joint] <= stg_i.meas;
    end
  end

  // Stage register toward the multipliers.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      stg_q <= stg_d;
    end
  end

  assign stg_o = stg_q;

endmodule

### src/tjpid_mac.sv
// Gain multiplies and fixed-point accumulation over two register stages.
`timescale 1ns / 1ps

module tjpid_mac (
  input  logic                                    clk_i,
  input  tjpid_pkg::mac_ctl_t                     ctl_i,
  input  tjpid_pkg::pid_stage_t                   stg_i,
  input  tjpid_pkg::gains_t                       gains_i,
  output logic                                    joint_o,
  output logic signed [tjpid_pkg::ACC_BITS-1:0]   acc_o
);

  logic signed [tjpid_pkg::KP_BITS:0]        kp_s;
  logic signed [tjpid_pkg::KG_BITS:0]        ki_s;
  logic signed [tjpid_pkg::KG_BITS:0]        kd_s;
  logic signed [tjpid_pkg::KP_PROD_BITS-1:0] kp_prod_d, kp_prod_q;
  logic signed [tjpid_pkg::KI_PROD_BITS-1:0] ki_prod_d, ki_prod_q;
  logic signed [tjpid_pkg::KD_PROD_BITS-1:0] kd_prod_d, kd_prod_q;
  logic                                      prod_joint_q;
  logic signed [tjpid_pkg::ACC_BITS-1:0]     acc_d, acc_q;
  logic                                      acc_joint_q;

  // Three products on the selected joint's gains.
  always_comb begin
    kp_s      = $signed({1'b0, gains_i.kp[stg_i.joint]});
    ki_s      = $signed({1'b0, gains_i.ki[stg_i.joint]});
    kd_s      = $signed({1'b0, gains_i.kd[stg_i.joint]});
    kp_prod_d = tjpid_pkg::KP_PROD_BITS'(kp_s) * tjpid_pkg::KP_PROD_BITS'(stg_i.err_db);
    ki_prod_d = tjpid_pkg::KI_PROD_BITS'(ki_s) * tjpid_pkg::KI_PROD_BITS'(stg_i.isum);
    kd_prod_d = tjpid_pkg::KD_PROD_BITS'(kd_s) * tjpid_pkg::KD_PROD_BITS'(stg_i.diff);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_prod) begin
      kp_prod_q    <= kp_prod_d;
      ki_prod_q    <= ki_prod_d;
      kd_prod_q    <= kd_prod_d;
      prod_joint_q <= stg_i.joint;
    end
  end

  // The proportional term carries whole units, so it is aligned to the Q16 terms.
  assign acc_d = (tjpid_pkg::ACC_BITS'(kp_prod_q) <<< tjpid_pkg::FRAC_BITS)
               + tjpid_pkg::ACC_BITS'(ki_prod_q)
               + tjpid_pkg::ACC_BITS'(kd_prod_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_acc) begin
      acc_q       <= acc_d;
      acc_joint_q <= prod_joint_q;
    end
  end

  assign joint_o = acc_joint_q;
  assign acc_o   = acc_q;

endmodule
